// ----- sv/sdc_pkg.sv -----
// Shared types and constants for the siren dead man's switch controller.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package sdc_pkg;

    // Width of the auto-off elapsed counter.
    localparam int SIREN_TIMER_BITS = 24;

    localparam int MAX_W   = 24;  // auto-off limit register width
    localparam int CNT_W   = 16;  // width of the 16-bit registers and counters
    localparam int CFG_W   = 24;  // widest configuration register
    localparam int IDX_W   = 3;   // configuration register index width
    localparam int CMP_W   = (SIREN_TIMER_BITS > MAX_W) ? SIREN_TIMER_BITS : MAX_W;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_SIREN_MAX    = 3'd0;
    localparam logic [IDX_W-1:0] REG_GRACE        = 3'd1;
    localparam logic [IDX_W-1:0] REG_PULSE_PERIOD = 3'd2;
    localparam logic [IDX_W-1:0] REG_PULSE_WIDTH  = 3'd3;
    localparam logic [IDX_W-1:0] REG_BROKER_HALF  = 3'd4;
    localparam logic [IDX_W-1:0] REG_LINK_HALF    = 3'd5;

    // Values after reset: two minutes of siren, three second grace.
    localparam logic [MAX_W-1:0] SIREN_MAX_RST    = 24'd120000;
    localparam logic [CNT_W-1:0] GRACE_RST        = 16'd3000;
    localparam logic [CNT_W-1:0] PULSE_PERIOD_RST = 16'd3000;
    localparam logic [CNT_W-1:0] PULSE_WIDTH_RST  = 16'd60;
    localparam logic [CNT_W-1:0] BROKER_HALF_RST  = 16'd400;
    localparam logic [CNT_W-1:0] LINK_HALF_RST    = 16'd100;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_ON   = 2'd1,
        ACT_OFF  = 2'd2,
        ACT_SUB  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        MODE_CONNECTING = 2'd0,
        MODE_BROKER     = 2'd1,
        MODE_ARMED      = 2'd2,
        MODE_FIRING     = 2'd3
    } led_mode_t;

    typedef struct packed {
        logic [1:0] action;
        logic       link_up;
        logic       broker_up;
    } in_item_t;

    typedef struct packed {
        logic       siren_on;
        logic       led_on;
        logic [1:0] led_mode;
    } out_item_t;

    typedef struct packed {
        logic [MAX_W-1:0] auto_off_ms;
        logic [CNT_W-1:0] grace_ms;
        logic [CNT_W-1:0] beat_period_ms;
        logic [CNT_W-1:0] beat_len_ms;
        logic [CNT_W-1:0] broker_half_ms;
        logic [CNT_W-1:0] link_half_ms;
    } cfg_t;

endpackage

// ----- sv/sdc_core.sv -----
// Siren controller state and the single-pass update for one request.
// Depends on sdc_pkg for the item, configuration and code types.
`timescale 1ns / 1ps

module sdc_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  sdc_pkg::in_item_t  item,
    input  sdc_pkg::cfg_t      cfg,
    output sdc_pkg::out_item_t result
);

    localparam logic [sdc_pkg::SIREN_TIMER_BITS-1:0] TIMER_CAP = '1;
    localparam logic [sdc_pkg::CNT_W-1:0]            SUB_CAP   = '1;

    logic                                  siren_active_reg, siren_active_next;
    logic [sdc_pkg::SIREN_TIMER_BITS-1:0]  siren_elapsed_reg, siren_elapsed_next;
    logic [sdc_pkg::CNT_W-1:0]             since_sub_reg, since_sub_next;
    logic [sdc_pkg::CNT_W-1:0]             pulse_phase_reg, pulse_phase_next;
    logic [sdc_pkg::CNT_W:0]               broker_phase_reg, broker_phase_next;
    logic [sdc_pkg::CNT_W:0]               link_phase_reg, link_phase_next;

    logic [sdc_pkg::SIREN_TIMER_BITS-1:0]  elapsed_inc;
    logic [sdc_pkg::CNT_W:0]               pulse_sum;
    logic [1:0]                            mode;
    logic                                  led;

    // The top bit of a blink phase is the light parity; the rest counts ticks.
    function automatic logic [sdc_pkg::CNT_W:0] blink_advance(
        input logic [sdc_pkg::CNT_W:0]   phase,
        input logic [sdc_pkg::CNT_W-1:0] half
    );
        logic [sdc_pkg::CNT_W:0] cnt;
        logic                    par;
        cnt = {1'b0, phase[sdc_pkg::CNT_W-1:0]} + 1'b1;
        par = phase[sdc_pkg::CNT_W];
        if (cnt >= {1'b0, half})
        begin
            cnt = '0;
            par = ~par;
        end
        return {par, cnt[sdc_pkg::CNT_W-1:0]};
    endfunction

    always_comb
    begin
        siren_active_next  = siren_active_reg;
        siren_elapsed_next = siren_elapsed_reg;
        since_sub_next     = since_sub_reg;
        pulse_phase_next   = pulse_phase_reg;
        broker_phase_next  = broker_phase_reg;
        link_phase_next    = link_phase_reg;

        elapsed_inc = (siren_elapsed_reg == TIMER_CAP) ? siren_elapsed_reg
                                                        : siren_elapsed_reg + 1'b1;
        pulse_sum   = {1'b0, pulse_phase_reg} + 1'b1;

        if (accept)
        begin
            case (item.action)
                sdc_pkg::ACT_TICK:
                begin
                    if (since_sub_reg != SUB_CAP)
                    begin
                        since_sub_next = since_sub_reg + 1'b1;
                    end
                    pulse_phase_next = (pulse_sum >= {1'b0, cfg.beat_period_ms})
                                       ? '0 : pulse_sum[sdc_pkg::CNT_W-1:0];
                    broker_phase_next = blink_advance(broker_phase_reg, cfg.broker_half_ms);
                    link_phase_next   = blink_advance(link_phase_reg, cfg.link_half_ms);
                    if (siren_active_reg)
                    begin
                        siren_elapsed_next = elapsed_inc;
                        // Saturation of a short timer also ends the alarm.
                        if ((sdc_pkg::CMP_W'(elapsed_inc) >= sdc_pkg::CMP_W'(cfg.auto_off_ms))
                            || (elapsed_inc == TIMER_CAP))
                        begin
                            siren_active_next = 1'b0;
                        end
                    end
                end
                sdc_pkg::ACT_ON:
                begin
                    if (since_sub_reg >= cfg.grace_ms)
                    begin
                        siren_active_next  = 1'b1;
                        siren_elapsed_next = '0;
                    end
                end
                sdc_pkg::ACT_OFF:
                begin
                    siren_active_next = 1'b0;
                end
                default:
                begin
                    since_sub_next = '0;
                end
            endcase
        end

        // Status light reflects the state after this request's update.
        if (siren_active_next)
        begin
            mode = sdc_pkg::MODE_FIRING;
        end
        else if (item.broker_up)
        begin
            mode = sdc_pkg::MODE_ARMED;
        end
        else if (item.link_up)
        begin
            mode = sdc_pkg::MODE_BROKER;
        end
        else
        begin
            mode = sdc_pkg::MODE_CONNECTING;
        end

        unique case (mode)
            sdc_pkg::MODE_FIRING:  led = 1'b1;
            sdc_pkg::MODE_ARMED:   led = (pulse_phase_next < cfg.beat_len_ms);
            sdc_pkg::MODE_BROKER:  led = broker_phase_next[sdc_pkg::CNT_W];
            default:               led = link_phase_next[sdc_pkg::CNT_W];
        endcase

        result.siren_on = siren_active_next;
        result.led_on   = led;
        result.led_mode = mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            siren_active_reg  <= 1'b0;
            siren_elapsed_reg <= '0;
            since_sub_reg     <= '0;
            pulse_phase_reg   <= '0;
            broker_phase_reg  <= '0;
            link_phase_reg    <= '0;
        end
        else
        begin
            siren_active_reg  <= siren_active_next;
            siren_elapsed_reg <= siren_elapsed_next;
            since_sub_reg     <= since_sub_next;
            pulse_phase_reg   <= pulse_phase_next;
            broker_phase_reg  <= broker_phase_next;
            link_phase_reg    <= link_phase_next;
        end
    end

endmodule

// ----- sv/sdc_outbuf.sv -----
// Two-entry result buffer: an output register backed by a skid register.
// Depends on sdc_pkg for the result type.
`timescale 1ns / 1ps

module sdc_outbuf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sdc_pkg::out_item_t push_data,
    output logic               space,
    output logic               out_valid,
    input  logic               out_ready,
    output sdc_pkg::out_item_t out_data
);

    logic               out_valid_reg, out_valid_next;
    logic               skid_valid_reg, skid_valid_next;
    sdc_pkg::out_item_t out_data_reg, out_data_next;
    sdc_pkg::out_item_t skid_data_reg, skid_data_next;
    logic               pop;

    assign pop       = out_valid_reg & out_ready;
    assign space     = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (pop) begin
            out_valid_next  = skid_valid_reg;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end

        // A new result lands in the first free slot, keeping order.
        if (push) begin
            if (!out_valid_next) begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ----- sv/siren_deadman_controller.sv -----
// Top level of the siren dead man's switch controller: configuration
// registers, the state update and the result buffer. Depends on sdc_pkg.
`timescale 1ns / 1ps

// Each request (a 1 ms tick, ON, OFF or subscription event, with link and
// broker status) yields one result: siren level, status light level and
// light mode. A request is taken while in_ready is high; the combinational
// state update puts its result in the output register, or in the skid
// register if that is occupied. One request per clock is sustained until
// both result slots fill during an output stall; in_ready then drops until
// a result leaves. Configuration is written through cfg_we, cfg_index and
// cfg_data while no requests are in flight; unused indexes are ignored.

module siren_deadman_controller (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  sdc_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output sdc_pkg::out_item_t          out_data,
    input  logic                        cfg_we,
    input  logic [sdc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [sdc_pkg::CFG_W-1:0]   cfg_data
);

    sdc_pkg::cfg_t      cfg_reg, cfg_next;
    sdc_pkg::out_item_t result;
    logic               accept;

    assign accept = in_valid & in_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                sdc_pkg::REG_SIREN_MAX:
                    cfg_next.auto_off_ms = cfg_data[sdc_pkg::MAX_W-1:0];
                sdc_pkg::REG_GRACE:
                    cfg_next.grace_ms = cfg_data[sdc_pkg::CNT_W-1:0];
                sdc_pkg::REG_PULSE_PERIOD:
                    cfg_next.beat_period_ms = cfg_data[sdc_pkg::CNT_W-1:0];
                sdc_pkg::REG_PULSE_WIDTH:
                    cfg_next.beat_len_ms = cfg_data[sdc_pkg::CNT_W-1:0];
                sdc_pkg::REG_BROKER_HALF:
                    cfg_next.broker_half_ms = cfg_data[sdc_pkg::CNT_W-1:0];
                sdc_pkg::REG_LINK_HALF:
                    cfg_next.link_half_ms = cfg_data[sdc_pkg::CNT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.auto_off_ms     <= sdc_pkg::SIREN_MAX_RST;
            cfg_reg.grace_ms        <= sdc_pkg::GRACE_RST;
            cfg_reg.beat_period_ms  <= sdc_pkg::PULSE_PERIOD_RST;
            cfg_reg.beat_len_ms     <= sdc_pkg::PULSE_WIDTH_RST;
            cfg_reg.broker_half_ms  <= sdc_pkg::BROKER_HALF_RST;
            cfg_reg.link_half_ms    <= sdc_pkg::LINK_HALF_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    sdc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (in_data),
        .cfg    (cfg_reg),
        .result (result)
    );

    sdc_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // The siren level and the firing mode must always agree.
    a_siren_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.siren_on == (out_data.led_mode == sdc_pkg::MODE_FIRING)))
        else $error("siren level and firing mode disagree");

    // While firing the light is solid.
    a_firing_led: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.siren_on) |-> out_data.led_on)
        else $error("light not solid while firing");

    // Requests are only held off when both result slots are occupied.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("request stalled with empty output");

    // An accepted OFF request leaves the siren silent.
    a_off_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_data.action == sdc_pkg::ACT_OFF)) |-> !result.siren_on)
        else $error("OFF request did not silence the siren");

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for siren_deadman_controller: directed and random
// requests, a request-level status predictor and per-field result checks.
// Depends on sdc_pkg and the siren_deadman_controller RTL.
`timescale 1ns / 1ps

module tb;
    import sdc_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 8;

    // Indexes the block has no register behind.
    localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    in_item_t         in_data = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    out_item_t        out_data;
    logic             cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    siren_deadman_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Mirror of the block's registers and state.
    cfg_t                        reg_mirror;
    logic                        siren_live;
    logic [SIREN_TIMER_BITS-1:0] siren_count;
    logic [CNT_W-1:0]            sub_age;
    logic [CNT_W-1:0]            pulse_pos;
    logic [CNT_W-1:0]            broker_cnt;
    logic                        broker_par;
    logic [CNT_W-1:0]            link_cnt;
    logic                        link_par;

    out_item_t pending_status[$];

    int  fail_count = 0;
    int  cycle_count = 0;
    int  req_count = 0;
    int  setting_count = 0;
    int  on_taken = 0;
    int  on_dropped = 0;
    int  auto_offs = 0;
    int  rx_stall_pct = 0;
    int  hold_off_req = 0;
    logic net_link = 1'b0;
    logic net_broker = 1'b0;

    function automatic void blink_tick(inout logic [CNT_W-1:0] cnt, inout logic par,
                                       input logic [CNT_W-1:0] half);
        logic [CNT_W:0] nxt;
        nxt = {1'b0, cnt} + 1'b1;
        if (nxt >= {1'b0, half})
        begin
            cnt = '0;
            par = ~par;
        end
        else
        begin
            cnt = nxt[CNT_W-1:0];
        end
    endfunction

    function automatic out_item_t predict_status(input in_item_t req);
        out_item_t      res;
        led_mode_t      mode;
        logic [CNT_W:0] nxt;
        case (action_t'(req.action))
            ACT_TICK:
            begin
                if (sub_age != '1)
                    sub_age = sub_age + 1'b1;
                nxt = {1'b0, pulse_pos} + 1'b1;
                pulse_pos = (nxt >= {1'b0, reg_mirror.beat_period_ms}) ? '0 : nxt[CNT_W-1:0];
                blink_tick(broker_cnt, broker_par, reg_mirror.broker_half_ms);
                blink_tick(link_cnt, link_par, reg_mirror.link_half_ms);
                if (siren_live)
                begin
                    if (siren_count != '1)
                        siren_count = siren_count + 1'b1;
                    if (siren_count >= reg_mirror.auto_off_ms || siren_count == '1)
                    begin
                        siren_live = 1'b0;
                        auto_offs++;
                    end
                end
            end
            ACT_ON:
            begin
                if (sub_age >= reg_mirror.grace_ms)
                begin
                    siren_live = 1'b1;
                    siren_count = '0;
                    on_taken++;
                end
                else
                begin
                    on_dropped++;
                end
            end
            ACT_OFF: siren_live = 1'b0;
            default: sub_age = '0;
        endcase

        if (siren_live)
            mode = MODE_FIRING;
        else if (req.broker_up)
            mode = MODE_ARMED;
        else if (req.link_up)
            mode = MODE_BROKER;
        else
            mode = MODE_CONNECTING;

        case (mode)
            MODE_FIRING:     res.led_on = 1'b1;
            MODE_ARMED:      res.led_on = (pulse_pos < reg_mirror.beat_len_ms);
            MODE_BROKER:     res.led_on = broker_par;
            default:         res.led_on = link_par;
        endcase
        res.siren_on = siren_live;
        res.led_mode = mode;
        return res;
    endfunction

    function automatic in_item_t make_req(input action_t act, input logic link,
                                          input logic broker);
        in_item_t req;
        req.action    = act;
        req.link_up   = link;
        req.broker_up = broker;
        return req;
    endfunction

    // Mostly ticks; the network status changes now and then, not every request.
    function automatic in_item_t next_traffic_req();
        int      pick;
        action_t act;
        if ($urandom_range(99) < 8)
            net_link = ~net_link;
        if ($urandom_range(99) < 8)
            net_broker = ~net_broker;
        pick = $urandom_range(99);
        if (pick < 68)
            act = ACT_TICK;
        else if (pick < 80)
            act = ACT_ON;
        else if (pick < 87)
            act = ACT_OFF;
        else
            act = ACT_SUB;
        return make_req(act, net_link, net_broker);
    endfunction

    task automatic send_req(input in_item_t req);
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_status.push_back(predict_status(req));
        req_count++;
    endtask

    task automatic pause_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_SIREN_MAX:    reg_mirror.auto_off_ms     = data[MAX_W-1:0];
            REG_GRACE:        reg_mirror.grace_ms        = data[CNT_W-1:0];
            REG_PULSE_PERIOD: reg_mirror.beat_period_ms  = data[CNT_W-1:0];
            REG_PULSE_WIDTH:  reg_mirror.beat_len_ms     = data[CNT_W-1:0];
            REG_BROKER_HALF:  reg_mirror.broker_half_ms  = data[CNT_W-1:0];
            REG_LINK_HALF:    reg_mirror.link_half_ms    = data[CNT_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_traffic(input int count, input int gap_max);
        int burst_left;
        burst_left = $urandom_range(16, 1);
        for (int n = 0; n < count; n++)
        begin
            send_req(next_traffic_req());
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(16, 1);
                if (gap_max > 0)
                    pause_sender($urandom_range(gap_max, 1));
            end
        end
    endtask

    // Default registers: an early ON falls inside the grace window after reset.
    task automatic test_after_reset();
        rx_stall_pct = 30;
        send_req(make_req(ACT_ON, 1'b0, 1'b0));
        send_req(make_req(ACT_TICK, 1'b0, 1'b0));
        send_req(make_req(ACT_TICK, 1'b1, 1'b0));
        send_req(make_req(ACT_TICK, 1'b0, 1'b1));
        send_req(make_req(ACT_TICK, 1'b1, 1'b1));
        send_req(make_req(ACT_OFF, 1'b1, 1'b1));
        send_req(make_req(ACT_SUB, 1'b1, 1'b0));
        send_req(make_req(ACT_ON, 1'b0, 1'b1));
        drain();
    endtask

    task automatic test_register_extremes();
        // Some 16-bit registers get junk in the upper data bits, which must be dropped.
        write_reg(REG_SIREN_MAX, 24'd1);
        write_reg(REG_GRACE, 24'd0);
        write_reg(REG_PULSE_PERIOD, 24'd1);
        write_reg(REG_PULSE_WIDTH, 24'hA5FFFF);
        write_reg(REG_BROKER_HALF, 24'h3C0000);
        write_reg(REG_LINK_HALF, 24'hC3FFFF);
        write_reg(REG_SPARE_A, 24'hFFFFFF);
        write_reg(REG_SPARE_B, 24'h000000);
        setting_count++;
        send_req(make_req(ACT_ON, 1'b0, 1'b1));
        send_req(make_req(ACT_TICK, 1'b0, 1'b1));
        send_req(make_req(ACT_TICK, 1'b1, 1'b0));
        send_req(make_req(ACT_TICK, 1'b1, 1'b0));
        send_req(make_req(ACT_TICK, 1'b0, 1'b0));
        send_req(make_req(ACT_OFF, 1'b1, 1'b1));
        drain();

        // A zero limit stops the siren on the next tick; zero period pins the pulse.
        write_reg(REG_SIREN_MAX, 24'd0);
        write_reg(REG_PULSE_WIDTH, 24'd0);
        write_reg(REG_PULSE_PERIOD, 24'd0);
        setting_count++;
        send_req(make_req(ACT_ON, 1'b0, 1'b1));
        send_req(make_req(ACT_TICK, 1'b0, 1'b1));
        drain();

        // Lowering the period below the running phase wraps it on the next tick.
        write_reg(REG_PULSE_PERIOD, 24'd8);
        write_reg(REG_PULSE_WIDTH, 24'd4);
        setting_count++;
        repeat (6) send_req(make_req(ACT_TICK, 1'b0, 1'b1));
        drain();
        write_reg(REG_PULSE_PERIOD, 24'd3);
        setting_count++;
        send_req(make_req(ACT_TICK, 1'b0, 1'b1));
        drain();
    endtask

    // ON is dropped until the grace window after a subscription has fully passed,
    // then the siren runs until the auto-off limit.
    task automatic test_grace_window();
        rx_stall_pct = 0;
        write_reg(REG_SIREN_MAX, 24'd10);
        write_reg(REG_GRACE, 24'd20);
        write_reg(REG_PULSE_PERIOD, 24'd16);
        write_reg(REG_PULSE_WIDTH, 24'd5);
        write_reg(REG_BROKER_HALF, 24'd3);
        write_reg(REG_LINK_HALF, 24'd2);
        setting_count++;
        send_req(make_req(ACT_SUB, 1'b1, 1'b1));
        repeat (18)
            send_req(make_req(ACT_TICK, 1'b1, 1'b0));
        send_req(make_req(ACT_ON, 1'b0, 1'b0));
        send_req(make_req(ACT_TICK, 1'b1, 1'b0));
        send_req(make_req(ACT_ON, 1'b1, 1'b0));
        send_req(make_req(ACT_TICK, 1'b0, 1'b1));
        send_req(make_req(ACT_ON, 1'b1, 1'b0));
        repeat (12)
            send_req(make_req(ACT_TICK, 1'b0, 1'b1));
        send_req(make_req(ACT_ON, 1'b0, 1'b0));
        send_req(make_req(ACT_OFF, 1'b0, 1'b1));
        drain();
    endtask

    task automatic test_random_settings();
        int gap_max;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 5)
            begin
                write_reg(REG_SIREN_MAX, 24'hFFFFFF);
                write_reg(REG_GRACE, 24'd0);
                write_reg(REG_PULSE_PERIOD, 24'h00FFFF);
                write_reg(REG_PULSE_WIDTH, 24'd0);
                write_reg(REG_BROKER_HALF, 24'h00FFFF);
                write_reg(REG_LINK_HALF, 24'd1);
            end
            else
            begin
                write_reg(REG_SIREN_MAX, 24'($urandom_range(40)));
                write_reg(REG_GRACE, {8'($urandom), 16'($urandom_range(25))});
                write_reg(REG_PULSE_PERIOD, {8'($urandom), 16'($urandom_range(24))});
                write_reg(REG_PULSE_WIDTH, {8'($urandom), 16'($urandom_range(24))});
                write_reg(REG_BROKER_HALF, {8'($urandom), 16'($urandom_range(12))});
                write_reg(REG_LINK_HALF, {8'($urandom), 16'($urandom_range(12))});
            end
            setting_count++;
            if (phase == 0)
            begin
                gap_max = 0;
                rx_stall_pct = 0;
            end
            else
            begin
                gap_max = $urandom_range(8, 1);
                rx_stall_pct = $urandom_range(60, 10);
            end
            run_traffic(190, gap_max);
            drain();
        end
    endtask

    // The receiver holds off long enough for the block to fill and stall requests.
    task automatic test_backpressure();
        rx_stall_pct = 0;
        hold_off_req = 300;
        run_traffic(60, 0);
        drain();
    endtask

    initial
    begin : main
        reg_mirror.auto_off_ms     = SIREN_MAX_RST;
        reg_mirror.grace_ms        = GRACE_RST;
        reg_mirror.beat_period_ms  = PULSE_PERIOD_RST;
        reg_mirror.beat_len_ms     = PULSE_WIDTH_RST;
        reg_mirror.broker_half_ms  = BROKER_HALF_RST;
        reg_mirror.link_half_ms    = LINK_HALF_RST;
        siren_live  = 1'b0;
        siren_count = '0;
        sub_age     = '0;
        pulse_pos   = '0;
        broker_cnt  = '0;
        broker_par  = 1'b0;
        link_cnt    = '0;
        link_par    = 1'b0;
        setting_count = 1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_register_extremes();
        test_grace_window();
        test_random_settings();
        test_backpressure();

        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d requests over %0d register settings, with sender gaps,",
                 req_count, setting_count);
        $display("receiver stalls and a long hold-off: %0d ON taken, %0d dropped, %0d auto-offs.",
                 on_taken, on_dropped, auto_offs);
        if (fail_count == 0)
            $display("PASS siren_deadman_controller");
        else
            $display("FAIL siren_deadman_controller");
        $finish;
    end

    initial
    begin : receiver
        int   run_left;
        int   hold_left;
        logic rdy;
        run_left  = 0;
        hold_left = 0;
        rdy       = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req > 0)
            begin
                hold_left    = hold_off_req;
                hold_off_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (run_left > 0)
            begin
                run_left--;
            end
            else
            begin
                rdy      = ($urandom_range(99) >= rx_stall_pct);
                run_left = rdy ? $urandom_range(12, 1) : $urandom_range(6, 1);
            end
            out_ready <= rdy;
        end
    end

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_status.size() == 0)
            begin
                $error("Result arrived with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_status.pop_front();
                if (out_data.siren_on !== want.siren_on)
                begin
                    $error("siren_on: expected %0b, got %0b", want.siren_on, out_data.siren_on);
                    fail_count++;
                end
                if (out_data.led_on !== want.led_on)
                begin
                    $error("led_on: expected %0b, got %0b", want.led_on, out_data.led_on);
                    fail_count++;
                end
                if (out_data.led_mode !== want.led_mode)
                begin
                    $error("led_mode: expected %0d, got %0d", want.led_mode, out_data.led_mode);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run exceeded %0d cycles with %0d results outstanding.",
                     CYCLE_LIMIT, pending_status.size());
            $display("FAIL siren_deadman_controller");
            $finish;
        end
    end

endmodule
